/* sv/jfsp_pkg.sv */
package jfsp_pkg;

    // Bytes and marker codes that the parser recognizes.
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_SOI  = 8'hD8;
    localparam logic [7:0] BYTE_EOI  = 8'hD9;
    localparam logic [7:0] MARK_TEM  = 8'h00;
    localparam logic [7:0] MARK_ONE  = 8'h01;
    localparam logic [7:0] MARK_SOF0 = 8'hC0;
    localparam logic [7:0] MARK_SOF2 = 8'hC2;
    localparam logic [7:0] MARK_SOS  = 8'hDA;
    localparam logic [4:0] MARK_RST_PREFIX = 5'b11010;

    // Bytes between the SOF marker code and the height field.
    localparam logic [15:0] SOF_PAD_BYTES = 16'd3;
    localparam logic [15:0] LEN_FIELD_BYTES = 16'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_BAD_END   = 2'd2;
    localparam logic [1:0] ST_NO_FRAME  = 2'd3;

    // Parser phases, one-hot.
    typedef enum logic [12:0] {
        PH_START0  = 13'b0000000000001,
        PH_START1  = 13'b0000000000010,
        PH_HUNT    = 13'b0000000000100,
        PH_MARKER  = 13'b0000000001000,
        PH_LEN_HI  = 13'b0000000010000,
        PH_LEN_LO  = 13'b0000000100000,
        PH_SKIP    = 13'b0000001000000,
        PH_SOF_PAD = 13'b0000010000000,
        PH_H_HI    = 13'b0000100000000,
        PH_H_LO    = 13'b0001000000000,
        PH_W_HI    = 13'b0010000000000,
        PH_W_LO    = 13'b0100000000000,
        PH_IDLE    = 13'b1000000000000
    } phase_t;

    // One parse result.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } result_t;

endpackage

/* sv/jfsp_if.sv */
// Byte stream into the parser.
interface jfsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Per-file result out of the parser.
interface jfsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] image_width;
    logic [15:0] image_height;

    modport source (output valid, output status, output image_width, output image_height,
                    input ready);
    modport sink   (input valid, input status, input image_width, input image_height,
                    output ready);
endinterface

/* sv/jfsp_parser.sv */
module jfsp_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             enable,
    input  logic [7:0]       data_byte,
    input  logic             final_byte,
    output jfsp_pkg::result_t result
);
    import jfsp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic        start_ok_reg, start_ok_next;
    logic        dims_reg, dims_next;
    logic        failed_reg, failed_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  prev_reg;
    logic [15:0] seg_len;
    logic [15:0] skip_dec;
    logic        is_standalone;
    logic        tail_ok;

    assign seg_len       = {len_hi_reg, data_byte};
    assign skip_dec      = skip_reg - 16'd1;
    assign is_standalone = (data_byte == MARK_TEM) || (data_byte == MARK_ONE) ||
                           (data_byte[7:3] == MARK_RST_PREFIX);
    assign tail_ok       = (prev_reg == BYTE_FF) && (data_byte == BYTE_EOI);

    // Phase update for one byte.
    always_comb
    begin
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        len_hi_next   = len_hi_reg;
        start_ok_next = start_ok_reg;
        dims_next     = dims_reg;
        failed_next   = failed_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        case (phase_reg)
            PH_START0:
            begin
                phase_next = (data_byte == BYTE_FF) ? PH_START1 : PH_IDLE;
            end
            PH_START1:
            begin
                if (data_byte == BYTE_SOI)
                begin
                    start_ok_next = 1'b1;
                    phase_next    = PH_HUNT;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HUNT:
            begin
                if (data_byte == BYTE_FF)
                begin
                    phase_next = PH_MARKER;
                end
            end
            PH_MARKER:
            begin
                if (data_byte == BYTE_FF)
                begin
                    phase_next = PH_MARKER;
                end
                else if (is_standalone)
                begin
                    phase_next = PH_HUNT;
                end
                else if ((data_byte == MARK_SOF0) || (data_byte == MARK_SOF2))
                begin
                    skip_next  = SOF_PAD_BYTES;
                    phase_next = PH_SOF_PAD;
                end
                else if (data_byte == MARK_SOS)
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                len_hi_next = data_byte;
                phase_next  = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                if (seg_len < LEN_FIELD_BYTES)
                begin
                    failed_next = 1'b1;
                    phase_next  = PH_IDLE;
                end
                else
                begin
                    skip_next  = seg_len - LEN_FIELD_BYTES;
                    phase_next = (seg_len == LEN_FIELD_BYTES) ? PH_HUNT : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = PH_HUNT;
                end
            end
            PH_SOF_PAD:
            begin
                skip_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    phase_next = PH_H_HI;
                end
            end
            PH_H_HI:
            begin
                height_next = {data_byte, 8'h00};
                phase_next  = PH_H_LO;
            end
            PH_H_LO:
            begin
                height_next = {height_reg[15:8], data_byte};
                phase_next  = PH_W_HI;
            end
            PH_W_HI:
            begin
                width_next = {data_byte, 8'h00};
                phase_next = PH_W_LO;
            end
            PH_W_LO:
            begin
                width_next = {width_reg[15:8], data_byte};
                dims_next  = 1'b1;
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Result for a final byte, formed from the state after this byte.
    always_comb
    begin
        if (!start_ok_next)
        begin
            result.status = ST_BAD_START;
        end
        else if (!tail_ok)
        begin
            result.status = ST_BAD_END;
        end
        else if (!dims_next || failed_next)
        begin
            result.status = ST_NO_FRAME;
        end
        else
        begin
            result.status = ST_OK;
        end
        result.image_width  = (result.status == ST_OK) ? width_next : 16'd0;
        result.image_height = (result.status == ST_OK) ? height_next : 16'd0;
    end

    // Parser state; a final byte returns everything to its reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START0;
            skip_reg     <= 16'd0;
            len_hi_reg   <= 8'd0;
            start_ok_reg <= 1'b0;
            dims_reg     <= 1'b0;
            failed_reg   <= 1'b0;
            width_reg    <= 16'd0;
            height_reg   <= 16'd0;
            prev_reg     <= 8'd0;
        end
        else if (enable)
        begin
            if (final_byte)
            begin
                phase_reg    <= PH_START0;
                skip_reg     <= 16'd0;
                len_hi_reg   <= 8'd0;
                start_ok_reg <= 1'b0;
                dims_reg     <= 1'b0;
                failed_reg   <= 1'b0;
                width_reg    <= 16'd0;
                height_reg   <= 16'd0;
                prev_reg     <= 8'd0;
            end
            else
            begin
                phase_reg    <= phase_next;
                skip_reg     <= skip_next;
                len_hi_reg   <= len_hi_next;
                start_ok_reg <= start_ok_next;
                dims_reg     <= dims_next;
                failed_reg   <= failed_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
                prev_reg     <= data_byte;
            end
        end
    end

endmodule

/* sv/jfsp_result_reg.sv */
module jfsp_result_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jfsp_pkg::result_t din,
    output logic              can_load,
    jfsp_out_if.source        result
);
    import jfsp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    // The slot is free when empty or when its request is taken this cycle.
    assign can_load   = !valid_reg || result.ready;
    assign valid_next = (valid_reg && !result.ready) || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload has no reset.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign result.valid        = valid_reg;
    assign result.status       = data_reg.status;
    assign result.image_width  = data_reg.image_width;
    assign result.image_height = data_reg.image_height;

endmodule

/* sv/jpeg_frame_size_parser.sv */
// JPEG frame-size parser. The file enters one byte per request on the stream
// channel, with final_byte set on its last byte; one result request follows
// each file with a status (ok, bad start marker, bad end marker, no frame
// header) and, when the status is ok, the width and height from the SOF0 or
// SOF2 frame header. A byte is registered at the input and then parsed by
// the phase logic, so the block takes one byte every clock unless stalled as
// below, and a final byte's result is then held in the result register. The
// stream stalls only when a final byte is ready to be parsed while the
// single result register still holds an untaken result; the parser state
// returns to its reset values after each file.
module jpeg_frame_size_parser (
    input  logic        clk,
    input  logic        rst_n,
    jfsp_in_if.sink     stream,
    jfsp_out_if.source  result
);
    import jfsp_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_final_reg;
    logic       advance;
    logic       can_load;
    logic       load;
    result_t    parse_result;

    // The registered byte moves on unless its result has nowhere to go.
    assign advance      = in_valid_reg && (!in_final_reg || can_load);
    assign load         = advance && in_final_reg;
    assign stream.ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (stream.ready)
        begin
            in_valid_reg <= stream.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stream.ready && stream.valid)
        begin
            in_byte_reg  <= stream.data_byte;
            in_final_reg <= stream.final_byte;
        end
    end

    jfsp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (advance),
        .data_byte  (in_byte_reg),
        .final_byte (in_final_reg),
        .result     (parse_result)
    );

    jfsp_result_reg u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .din      (parse_result),
        .can_load (can_load),
        .result   (result)
    );

`ifndef NO_ASSERTIONS
    // A parsed final byte always produces a pending result.
    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result.valid)
        else $error("final byte did not produce a result");

    // Only a final byte can hold the input register.
    a_stall_only_final: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> (in_final_reg && result.valid && !result.ready))
        else $error("input stalled without a blocked result");

    // Dimensions are reported only with an ok status.
    a_dims_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.status != ST_OK)) |->
        ((result.image_width == 16'd0) && (result.image_height == 16'd0)))
        else $error("nonzero dimensions with a failing status");
`endif

endmodule

/* tb/tb_jpeg_frame_size_parser.sv */
module tb_jpeg_frame_size_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import jfsp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_BYTES  = 650;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } stream_item_t;

    logic clk;
    logic rst_n = 1'b0;

    // Signals that the testbench drives, known from time zero.
    logic       drv_valid  = 1'b0;
    logic [7:0] drv_byte   = 8'h00;
    logic       drv_final  = 1'b0;
    logic       take_ready = 1'b0;

    jfsp_in_if  stream_bus ();
    jfsp_out_if result_bus ();

    assign stream_bus.valid      = drv_valid;
    assign stream_bus.data_byte  = drv_byte;
    assign stream_bus.final_byte = drv_final;
    assign result_bus.ready      = take_ready;

    jpeg_frame_size_parser dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_bus),
        .result (result_bus)
    );

    // Bytes waiting to be sent and the dimension results they should produce.
    stream_item_t pending_bytes[$];
    result_t      expected_dims[$];
    logic [7:0]   file_buf[$];

    int send_idle_pct = 0;
    int take_idle_pct = 0;
    int error_count = 0;
    int results_checked = 0;
    int bytes_accepted = 0;
    int holdoffs = 0;
    int cycle_count = 0;
    int status_seen[4];

    // Shadow of the parser state.
    phase_t      parse_ph;
    logic [15:0] skip_left;
    logic [7:0]  len_hi_q;
    logic        soi_seen;
    logic        dims_done;
    logic        search_dead;
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic [7:0]  prev_q;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic void clear_parse_state();
        parse_ph    = PH_START0;
        skip_left   = '0;
        len_hi_q    = '0;
        soi_seen    = 1'b0;
        dims_done   = 1'b0;
        search_dead = 1'b0;
        width_q     = '0;
        height_q    = '0;
        prev_q      = '0;
    endfunction

    // Advance the shadow parser by one byte; on the last byte of a file,
    // queue the status and dimensions that the block should report.
    task automatic track_jpeg_byte(input logic [7:0] b, input logic last);
        logic        tail_ok;
        logic [15:0] seg_len;
        logic [1:0]  st;
        result_t     res;
        tail_ok = (prev_q == BYTE_FF) && (b == BYTE_EOI);
        case (parse_ph)
            PH_START0:
                parse_ph = (b == BYTE_FF) ? PH_START1 : PH_IDLE;
            PH_START1:
                if (b == BYTE_SOI)
                begin
                    soi_seen = 1'b1;
                    parse_ph = PH_HUNT;
                end
                else
                    parse_ph = PH_IDLE;
            PH_HUNT:
                if (b == BYTE_FF)
                    parse_ph = PH_MARKER;
            PH_MARKER:
                // Fill bytes keep the parser waiting for the marker code.
                if (b != BYTE_FF)
                begin
                    if (b == MARK_TEM || b == MARK_ONE || b[7:3] == MARK_RST_PREFIX)
                        parse_ph = PH_HUNT;
                    else if (b == MARK_SOF0 || b == MARK_SOF2)
                    begin
                        skip_left = SOF_PAD_BYTES;
                        parse_ph  = PH_SOF_PAD;
                    end
                    else if (b == MARK_SOS)
                    begin
                        search_dead = 1'b1;
                        parse_ph    = PH_IDLE;
                    end
                    else
                        parse_ph = PH_LEN_HI;
                end
            PH_LEN_HI:
            begin
                len_hi_q = b;
                parse_ph = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                seg_len = {len_hi_q, b};
                if (seg_len < LEN_FIELD_BYTES)
                begin
                    search_dead = 1'b1;
                    parse_ph    = PH_IDLE;
                end
                else
                begin
                    skip_left = seg_len - LEN_FIELD_BYTES;
                    parse_ph  = (skip_left == 16'd0) ? PH_HUNT : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0)
                    parse_ph = PH_HUNT;
            end
            PH_SOF_PAD:
            begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0)
                    parse_ph = PH_H_HI;
            end
            PH_H_HI:
            begin
                height_q = {b, 8'h00};
                parse_ph = PH_H_LO;
            end
            PH_H_LO:
            begin
                height_q[7:0] = b;
                parse_ph      = PH_W_HI;
            end
            PH_W_HI:
            begin
                width_q  = {b, 8'h00};
                parse_ph = PH_W_LO;
            end
            PH_W_LO:
            begin
                width_q[7:0] = b;
                dims_done    = 1'b1;
                parse_ph     = PH_IDLE;
            end
            default:
                parse_ph = PH_IDLE;
        endcase
        prev_q = b;
        bytes_accepted++;

        if (last)
        begin
            if (!soi_seen)
                st = ST_BAD_START;
            else if (!tail_ok)
                st = ST_BAD_END;
            else if (!dims_done || search_dead)
                st = ST_NO_FRAME;
            else
                st = ST_OK;
            res.status       = st;
            res.image_width  = (st == ST_OK) ? width_q : 16'd0;
            res.image_height = (st == ST_OK) ? height_q : 16'd0;
            expected_dims.push_back(res);
            status_seen[st]++;
            clear_parse_state();
        end
    endtask

    // Byte sender: updates the shadow parser on every accepted request and
    // presents the next pending byte unless it decides to idle.
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        stream_item_t nxt;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
            drv_byte  <= 8'h00;
            drv_final <= 1'b0;
        end
        else
        begin
            if (drv_valid && stream_bus.ready)
                track_jpeg_byte(drv_byte, drv_final);
            if (!drv_valid || stream_bus.ready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    drv_valid <= 1'b1;
                    drv_byte  <= nxt.value;
                    drv_final <= nxt.last;
                end
                else
                    drv_valid <= 1'b0;
            end
        end
    end

    // Result receiver: compares each accepted request with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        result_t want;
        if (!rst_n)
            take_ready <= 1'b0;
        else
        begin
            if (result_bus.valid && take_ready)
            begin
                if (expected_dims.size() == 0)
                    flag_error($sformatf("unexpected result: status %0d width %0d height %0d",
                                         result_bus.status, result_bus.image_width,
                                         result_bus.image_height));
                else
                begin
                    want = expected_dims.pop_front();
                    if (result_bus.status !== want.status)
                        flag_error($sformatf("status %0d, expected %0d",
                                             result_bus.status, want.status));
                    if (result_bus.image_width !== want.image_width)
                        flag_error($sformatf("width %0d, expected %0d",
                                             result_bus.image_width, want.image_width));
                    if (result_bus.image_height !== want.image_height)
                        flag_error($sformatf("height %0d, expected %0d",
                                             result_bus.image_height, want.image_height));
                    results_checked++;
                end
            end
            take_ready <= ($urandom_range(0, 99) >= take_idle_pct);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, expected_dims.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Any marker code that the parser treats as a length-prefixed segment.
    function automatic logic [7:0] pick_plain_marker();
        logic [7:0] m;
        do
            m = 8'($urandom_range(0, 255));
        while (m == BYTE_FF || m == MARK_TEM || m == MARK_ONE || m[7:3] == MARK_RST_PREFIX ||
               m == MARK_SOF0 || m == MARK_SOF2 || m == MARK_SOS);
        return m;
    endfunction

    task automatic add_random_bytes(input int count);
        logic [7:0] b;
        repeat (count)
        begin
            b = 8'($urandom_range(0, 255));
            file_buf.push_back(b);
        end
    endtask

    // Marker with an occasional run of fill bytes in front of the code.
    task automatic add_marker(input logic [7:0] code);
        file_buf.push_back(BYTE_FF);
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3))
                file_buf.push_back(BYTE_FF);
        file_buf.push_back(code);
    endtask

    // Stray non-FF bytes and standalone markers between segments.
    task automatic add_filler();
        logic [7:0] b;
        logic [2:0] rst_idx;
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3))
            begin
                b = 8'($urandom_range(0, 254));
                file_buf.push_back(b);
            end
        if ($urandom_range(0, 4) == 0)
        begin
            rst_idx = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 2))
                0: add_marker(MARK_TEM);
                1: add_marker(MARK_ONE);
                default: add_marker({MARK_RST_PREFIX, rst_idx});
            endcase
        end
    endtask

    // Length-prefixed segment; mostly short, a few long or with a bad length.
    task automatic add_segment();
        int r;
        int seg_len;
        add_marker(pick_plain_marker());
        r = $urandom_range(0, 99);
        if (r < 3)
            seg_len = $urandom_range(0, 1);
        else if (r < 8)
            seg_len = 2;
        else if (r < 95)
            seg_len = $urandom_range(3, 16);
        else if (r < 99)
            seg_len = $urandom_range(17, 300);
        else
            seg_len = $urandom_range(301, 700);
        file_buf.push_back(seg_len[15:8]);
        file_buf.push_back(seg_len[7:0]);
        if (seg_len >= 2)
            add_random_bytes(seg_len - 2);
    endtask

    // Baseline or progressive frame header with random dimensions.
    task automatic add_frame_header();
        logic [15:0] h;
        logic [15:0] w;
        int          ncomp;
        int          hdr_len;
        h = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(1, 4096));
        w = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(1, 4096));
        add_marker($urandom_range(0, 1) ? MARK_SOF2 : MARK_SOF0);
        ncomp   = $urandom_range(1, 3);
        hdr_len = 8 + 3 * ncomp;
        file_buf.push_back(hdr_len[15:8]);
        file_buf.push_back(hdr_len[7:0]);
        file_buf.push_back(8'h08);
        file_buf.push_back(h[15:8]);
        file_buf.push_back(h[7:0]);
        file_buf.push_back(w[15:8]);
        file_buf.push_back(w[7:0]);
        file_buf.push_back(ncomp[7:0]);
        add_random_bytes(3 * ncomp);
    endtask

    // A mostly well-formed file: start marker, segments, frame header, scan
    // data and end marker, with a few variations that make the search fail.
    task automatic build_jpeg();
        int kind;
        int end_kind;
        logic [7:0] b;
        file_buf.push_back(BYTE_FF);
        file_buf.push_back(BYTE_SOI);
        repeat ($urandom_range(0, 3))
        begin
            add_filler();
            add_segment();
        end
        kind = $urandom_range(0, 19);
        if (kind == 0)
            add_marker(MARK_SOS);
        else if (kind != 1)
        begin
            add_frame_header();
            repeat ($urandom_range(0, 1))
            begin
                add_filler();
                add_segment();
            end
        end
        if ($urandom_range(0, 1) == 0)
            add_marker(MARK_SOS);
        add_random_bytes($urandom_range(0, 8));

        // Usually a proper end marker, sometimes a broken tail.
        end_kind = $urandom_range(0, 9);
        if (end_kind == 0)
            add_random_bytes(1);
        else if (end_kind == 1)
        begin
            b = 8'($urandom_range(0, 254));
            file_buf.push_back(b);
            file_buf.push_back(BYTE_EOI);
        end
        else
        begin
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(BYTE_EOI);
        end
    endtask

    task automatic send_file();
        stream_item_t it;
        foreach (file_buf[i])
        begin
            it.value = file_buf[i];
            it.last  = (i == file_buf.size() - 1);
            pending_bytes.push_back(it);
        end
        file_buf.delete();
    endtask

    // Mix of well-formed files, noise, damaged files and huge segment lengths.
    task automatic make_random_file();
        int r;
        int pos;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 76)
            build_jpeg();
        else if (r < 86)
        begin
            add_random_bytes($urandom_range(1, 20));
            if ($urandom_range(0, 2) == 0)
            begin
                file_buf.push_back(BYTE_FF);
                file_buf.push_back(BYTE_EOI);
            end
        end
        else if (r < 96)
        begin
            build_jpeg();
            if ($urandom_range(0, 1) == 0)
            begin
                pos = $urandom_range(0, file_buf.size() - 1);
                b = 8'($urandom_range(0, 255));
                file_buf[pos] = b;
            end
            else
            begin
                pos = $urandom_range(1, file_buf.size());
                while (file_buf.size() > pos)
                    void'(file_buf.pop_back());
            end
        end
        else
        begin
            // Segment length at the top of its range; the file ends mid-skip.
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(BYTE_SOI);
            add_marker(pick_plain_marker());
            file_buf.push_back(8'hFF);
            file_buf.push_back(8'hFF);
            add_random_bytes($urandom_range(0, 20));
            file_buf.push_back(BYTE_FF);
            file_buf.push_back(BYTE_EOI);
        end
        send_file();
    endtask

    task automatic wait_for_drain();
        while (pending_bytes.size() != 0 || drv_valid || expected_dims.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        int phase_start;
        clear_parse_state();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 17;
        take_idle_pct = 56;

        // One-byte file: the start marker cannot be there.
        file_buf = '{BYTE_EOI};
        send_file();
        // Good tail but a bad start marker.
        file_buf = '{BYTE_SOI, BYTE_FF, BYTE_EOI};
        send_file();
        // Scan starts before any frame header.
        file_buf = '{BYTE_FF, BYTE_SOI, BYTE_FF, MARK_SOS, BYTE_FF, BYTE_EOI};
        send_file();
        // Largest dimensions in a baseline frame header.
        file_buf = '{BYTE_FF, BYTE_SOI, BYTE_FF, MARK_SOF0, 8'h00, 8'h11, 8'h08,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, BYTE_FF, BYTE_EOI};
        send_file();
        // Progressive header whose width bytes are the end marker itself.
        file_buf = '{BYTE_FF, BYTE_SOI, BYTE_FF, MARK_SOF2, 8'h00, 8'h11, 8'h08,
                     8'h00, 8'h00, BYTE_FF, BYTE_EOI};
        send_file();
        wait_for_drain();

        // Three random phases: two with different idle mixes on the two sides, then none.
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 17;
                    take_idle_pct = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    take_idle_pct = 17;
                end
                default:
                begin
                    send_idle_pct = 0;
                    take_idle_pct = 0;
                end
            endcase
            phase_start = bytes_accepted + pending_bytes.size();
            while (bytes_accepted + pending_bytes.size() - phase_start < PHASE_BYTES)
            begin
                make_random_file();
                // Now and then hold the stream until every result is back.
                if ($urandom_range(0, 24) == 0)
                begin
                    wait_for_drain();
                    holdoffs++;
                end
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d results over %0d bytes: %0d ok, %0d bad start,",
                 results_checked, bytes_accepted, status_seen[ST_OK],
                 status_seen[ST_BAD_START]);
        $display("%0d bad end, %0d without frame header.",
                 status_seen[ST_BAD_END], status_seen[ST_NO_FRAME]);
        $display("Both sides stalled in two mixes, then ran at full rate; %s %0d times.",
                 "the stream was held for a drain", holdoffs + 4);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
